// ===== hw/rtl/aki_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aki_pkg
// Shared types, constants and AES helper functions for the keyed index block.
// ----------------------------------------------------------------------------
package aki_pkg;

  // Round key storage: one 128-bit key per cipher round, up to AES-256.
  localparam int NUM_RK     = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int MOD_STAGES = 64;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_A    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_B    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_C    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_D    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_MODE = 3'd4;

  // Key size codes.
  localparam logic [1:0] KEY_MODE_128 = 2'd0;
  localparam logic [1:0] KEY_MODE_192 = 2'd1;

  typedef logic [NUM_RK-1:0][127:0] rk_array_t;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_LOAD,
    KX_RUN
  } kx_state_t;

  // Status of the key expander as seen by the datapath.
  typedef struct packed {
    logic       busy;
    logic [3:0] num_rounds;
  } kx_status_t;

  // Per-item information that travels beside the cipher state.
  typedef struct packed {
    logic        use_limit;
    logic [30:0] limit;
  } side_t;

  // One stage of the restoring remainder pipeline.
  typedef struct packed {
    logic [63:0] val;
    logic [30:0] rem;
    logic [30:0] lim;
    logic        red;
  } mod_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Substitute each byte of a 32-bit word.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One cipher round. Byte i of the state sits in bits 127-8i down.
  // An inactive round passes the state through unchanged.
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic do_mix,
                                             input logic active);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    int           row, col, src;
    for (int i = 0; i < 16; i++) begin
      row  = i & 3;
      col  = i >> 2;
      src  = row + 4 * ((col + row) & 3);
      t[i] = SBOX[s[127 - 8 * src -: 8]];
    end
    if (do_mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = t[i] ^ rk[127 - 8 * i -: 8];
    end
    return active ? r : s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes_keyed_prf_index.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_keyed_prf_index
// Keyed pseudo-random index: AES-128/192/256 of a 16-byte block, the first
// eight ciphertext bytes read little-endian, optionally reduced modulo limit.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one item per cycle while in_tready is high: the
//   padded block in in_tdata and the reduce flag in in_tuser. Each item gives
//   exactly one index on the out_ channel, in order. An accepted item passes
//   one key addition stage, fourteen unrolled round stages, 64 restoring
//   remainder stages (one quotient bit each) and the output register, the
//   first of these loaded at the edge that accepts it.
//   Throughput is one item per cycle unless key expansion or a held output stalls in_tready.
//   The cipher key is written through cfg_we/cfg_addr/cfg_wdata while the
//   block is idle. After reset and after each register write the round keys
//   are expanded one word per cycle; in_tready stays low during that pass:
//   the KX_LOAD state loads the key words, then the KX_RUN state adds one
//   expanded word per step until the last round key word is written.
//   When the receiver stalls, the output register holds its item and the
//   pipeline keeps moving until its last stage is full; only then does the
//   whole pipeline, and in_tready, hold.
// ----------------------------------------------------------------------------
module aes_keyed_prf_index (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Fields: block_high [63:0], block_low [127:64], limit [158:128], zero pad.
  input  wire logic [159:0]                   in_tdata,
  // Fields: use_limit [0].
  input  wire logic                           in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // Fields: index [31:0].
  output logic [31:0]                         out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_we,
  input  wire logic [aki_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [63:0]                    cfg_wdata
);
  import aki_pkg::*;

  rk_array_t         round_keys;
  kx_status_t        kx_stat;
  logic              pipe_en;
  logic              in_fire;
  side_t             in_side;
  logic              aes_vld;
  logic [127:0]      aes_block;
  side_t             aes_side;
  mod_t              mod_entry;
  mod_t              mod_r   [MOD_STAGES];
  logic [MOD_STAGES-1:0] mvld_r;
  logic              out_vld_r;
  logic [31:0]       out_data_r;
  mod_t              mod_last;

  // One remainder step: shift in the next dividend bit, subtract if it fits.
  function automatic mod_t mod_step(input mod_t m, input logic b);
    logic [31:0] part;
    mod_t        r;
    part = {m.rem, b};
    if (part >= {1'b0, m.lim}) begin
      part = part - {1'b0, m.lim};
    end
    r     = m;
    r.rem = part[30:0];
    return r;
  endfunction

  aki_key_expand u_key_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .round_keys (round_keys),
    .status     (kx_stat)
  );

  // The pipeline moves unless its last stage is full and the output is held.
  assign pipe_en   = !mvld_r[MOD_STAGES-1] || !out_vld_r || out_tready;
  assign in_tready = pipe_en && !kx_stat.busy;
  assign in_fire   = in_tvalid && in_tready;

  assign in_side.use_limit = in_tuser;
  assign in_side.limit     = in_tdata[158:128];

  aki_aes_pipe u_aes_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_vld     (in_fire),
    .in_block   ({in_tdata[63:0], in_tdata[127:64]}),
    .in_side    (in_side),
    .round_keys (round_keys),
    .num_rounds (kx_stat.num_rounds),
    .out_vld    (aes_vld),
    .out_block  (aes_block),
    .out_side   (aes_side)
  );

  // Ciphertext bytes 0 to 7 read as a little-endian value.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mod_entry.val[8 * i +: 8] = aes_block[127 - 8 * i -: 8];
    end
    mod_entry.rem = '0;
    mod_entry.lim = aes_side.limit;
    mod_entry.red = aes_side.use_limit && (aes_side.limit != '0);
  end

  // Remainder pipeline, most significant dividend bit first.
  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    logic src_vld;
    mod_t src;
    if (k == 0) begin : g_first
      assign src_vld = aes_vld;
      assign src     = mod_entry;
    end else begin : g_next
      assign src_vld = mvld_r[k-1];
      assign src     = mod_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mvld_r[k] <= 1'b0;
      end else if (pipe_en) begin
        mvld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        mod_r[k] <= mod_step(src, src.val[MOD_STAGES-1-k]);
      end
    end
  end

  assign mod_last = mod_r[MOD_STAGES-1];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= mvld_r[MOD_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      out_data_r <= mod_last.red ? {1'b0, mod_last.rem} : mod_last.val[31:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A register write always restarts the key expansion.
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_addr <= REG_KEY_MODE)) |=> kx_stat.busy)
    else $error("register write did not restart key expansion");

  // A finished item waiting behind a held output is not lost.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mvld_r[MOD_STAGES-1] && out_vld_r && !out_tready) |=> mvld_r[MOD_STAGES-1])
    else $error("last pipeline stage dropped an item during a stall");

  // No item enters while the round keys are being rebuilt.
  a_no_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(kx_stat.busy) && $past(pipe_en) |-> !$past(in_fire))
    else $error("item accepted during key expansion");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/aki_key_expand.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aki_key_expand
// Holds the cipher key registers and expands them into the round keys, one
// 32-bit key word per cycle, after reset and after every register write.
// ----------------------------------------------------------------------------
module aki_key_expand (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [aki_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [63:0]                    cfg_wdata,
  output aki_pkg::rk_array_t                  round_keys,
  output aki_pkg::kx_status_t                 status
);
  import aki_pkg::*;

  logic [63:0]       key_a_r, key_b_r, key_c_r, key_d_r;
  logic [1:0]        mode_r;
  kx_state_t         state_r, state_nxt;
  logic [0:7][31:0]  win_r;
  logic [5:0]        i_r;
  logic [2:0]        j_r;
  logic [7:0]        rcon_r;
  rk_array_t         rk_r;

  logic              cfg_hit;
  logic [255:0]      key_all;
  logic [0:7][31:0]  win_load;
  logic [31:0]       old_word, t_word, new_word;
  logic [3:0]        nr;
  logic [2:0]        nk_last;
  logic [5:0]        last_idx;
  logic              last_word;
  logic              is_256;

  assign cfg_hit = cfg_we && (cfg_addr <= REG_KEY_MODE);
  assign key_all = {key_a_r, key_b_r, key_c_r, key_d_r};

  // Key size dependent values; the unused codes 2'd2 and 2'd3 are both taken as a 256-bit key.
  always_comb begin
    case (mode_r)
      KEY_MODE_128: begin
        nr       = 4'd10;
        nk_last  = 3'd3;
        last_idx = 6'd43;
        is_256   = 1'b0;
        win_load = {128'd0, key_all[255:128]};
        old_word = win_r[4];
      end
      KEY_MODE_192: begin
        nr       = 4'd12;
        nk_last  = 3'd5;
        last_idx = 6'd51;
        is_256   = 1'b0;
        win_load = {64'd0, key_all[255:64]};
        old_word = win_r[2];
      end
      default: begin
        nr       = 4'd14;
        nk_last  = 3'd7;
        last_idx = 6'd59;
        is_256   = 1'b1;
        win_load = key_all;
        old_word = win_r[0];
      end
    endcase
  end

  // Next key word from the previous one and the one a key length back.
  always_comb begin
    if (j_r == 3'd0) begin
      t_word = sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'd0};
    end else if (is_256 && (j_r == 3'd4)) begin
      t_word = sub_word(win_r[7]);
    end else begin
      t_word = win_r[7];
    end
    new_word = old_word ^ t_word;
  end

  assign last_word = (i_r == last_idx);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
      mode_r  <= KEY_MODE_128;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_A:    key_a_r <= cfg_wdata;
        REG_KEY_B:    key_b_r <= cfg_wdata;
        REG_KEY_C:    key_c_r <= cfg_wdata;
        REG_KEY_D:    key_d_r <= cfg_wdata;
        REG_KEY_MODE: mode_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state: any register write restarts the expansion.
  always_comb begin
    state_nxt = state_r;
    if (cfg_hit) begin
      state_nxt = KX_LOAD;
    end else begin
      case (state_r)
        KX_LOAD: state_nxt = KX_RUN;
        KX_RUN:  if (last_word) state_nxt = KX_IDLE;
        KX_IDLE: state_nxt = KX_IDLE;
        default: state_nxt = KX_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KX_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Expansion datapath: load the key words, then one new word per cycle.
  always_ff @(posedge clk) begin
    if (state_r == KX_LOAD) begin
      win_r    <= win_load;
      rk_r[0]  <= key_all[255:128];
      rk_r[1]  <= key_all[127:0];
      i_r      <= {3'd0, nk_last} + 6'd1;
      j_r      <= 3'd0;
      rcon_r   <= 8'h01;
    end else if (state_r == KX_RUN) begin
      win_r <= {win_r[1:7], new_word};
      rk_r[i_r[5:2]][{~i_r[1:0], 5'd0} +: 32] <= new_word;
      i_r   <= i_r + 6'd1;
      j_r   <= (j_r == nk_last) ? 3'd0 : j_r + 3'd1;
      if (j_r == 3'd0) begin
        rcon_r <= xtime(rcon_r);
      end
    end
  end

  // Outputs.
  always_comb begin
    status.busy       = (state_r != KX_IDLE);
    status.num_rounds = nr;
    round_keys        = rk_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aki_aes_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aki_aes_pipe
// Fully unrolled AES encryption: an initial key addition stage and fourteen
// round stages, each registered. Rounds beyond the key size pass through.
// ----------------------------------------------------------------------------
module aki_aes_pipe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [127:0]        in_block,
  input  aki_pkg::side_t           in_side,
  input  aki_pkg::rk_array_t       round_keys,
  input  wire logic [3:0]          num_rounds,
  output logic                     out_vld,
  output logic [127:0]             out_block,
  output aki_pkg::side_t           out_side
);
  import aki_pkg::*;

  logic [NUM_RK-1:0] vld_r;
  logic [127:0]      st_r   [NUM_RK];
  side_t             side_r [NUM_RK];

  // Initial round key addition.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= in_block ^ round_keys[0];
      side_r[0] <= in_side;
    end
  end

  // One register stage per cipher round.
  for (genvar k = 1; k < NUM_RK; k++) begin : g_round
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k]   <= aes_round(st_r[k-1], round_keys[k],
                               (4'(k) < num_rounds), (4'(k) <= num_rounds));
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld   = vld_r[NUM_RK-1];
  assign out_block = st_r[NUM_RK-1];
  assign out_side  = side_r[NUM_RK-1];

endmodule
`default_nettype wire
